// File: rtl/bba_pkg.sv
package bba_pkg;

    localparam int COORD_BITS = 12;
    localparam int ALPHA_BITS = 8;
    localparam int FMT_BITS   = 2;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = COORD_BITS;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_BOX_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_BOX_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_FILL_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_OPACITY      = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_PIXEL_FORMAT = 3'd4;

    // pixel formats
    localparam logic [FMT_BITS-1:0] FMT_RGB565   = 2'd0;
    localparam logic [FMT_BITS-1:0] FMT_ARGB8888 = 2'd1;

    localparam logic [ALPHA_BITS-1:0] OPACITY_RESET = 8'd255;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // border and fill colors
    localparam logic [7:0] EDGE_GREY = 8'd128;
    localparam logic [7:0] FILL_R    = 8'd0;
    localparam logic [7:0] FILL_G    = 8'd150;
    localparam logic [7:0] FILL_B    = 8'd255;

    typedef struct packed {
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;
        logic [31:0]           background_pixel;
    } in_item_t;

    typedef struct packed {
        logic        write_pixel;
        logic [31:0] new_pixel;
    } out_item_t;

endpackage

// File: rtl/bordered_bar_alpha_blend.sv
// channel | direction | handshake               | payload
// in      | input     | in_valid / in_ready     | in_data (col, row, background_pixel)
// out     | output    | out_valid / out_ready   | out_data (write_pixel, new_pixel)
// cfg     | input     | cfg_write               | cfg_index, cfg_data
//
// four register stages: decode and unpack, multiply and add, divide by 255, pack.
// one item per cycle while the output is not stalled.
// a stage takes a new item when it is empty or its item moves on, so an item
// can enter while a finished one waits at the output.
// reset clears valid bits and sets configuration to defaults; pipeline payload is not reset.
module bordered_bar_alpha_blend (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  bba_pkg::in_item_t                    in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output bba_pkg::out_item_t                   out_data,
    input  logic                                 cfg_write,
    input  logic [bba_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [bba_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
    import bba_pkg::*;

    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
        return t[15:8];
    endfunction

    // configuration
    logic [COORD_BITS-1:0] box_width_reg;
    logic [COORD_BITS-1:0] box_height_reg;
    logic [COORD_BITS-1:0] fill_width_reg;
    logic [ALPHA_BITS-1:0] opacity_reg;
    logic [FMT_BITS-1:0]   pixel_format_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_width_reg    <= '0;
            box_height_reg   <= '0;
            fill_width_reg   <= '0;
            opacity_reg      <= OPACITY_RESET;
            pixel_format_reg <= FMT_RGB565;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_BOX_WIDTH:    box_width_reg    <= cfg_data[COORD_BITS-1:0];
                REG_BOX_HEIGHT:   box_height_reg   <= cfg_data[COORD_BITS-1:0];
                REG_FILL_WIDTH:   fill_width_reg   <= cfg_data[COORD_BITS-1:0];
                REG_OPACITY:      opacity_reg      <= cfg_data[ALPHA_BITS-1:0];
                REG_PIXEL_FORMAT: pixel_format_reg <= cfg_data[FMT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // stage valid bits and per-stage ready chain
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s1_ready, s2_ready, s3_ready, s4_ready;

    assign s4_ready = !s4_valid_reg || out_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= in_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (s3_ready)
                s3_valid_reg <= s2_valid_reg;
            if (s4_ready)
                s4_valid_reg <= s3_valid_reg;
        end
    end

    // stage 1: classify the pixel, pick the color, unpack the background
    logic       s1_draw_next, s1_draw_reg;
    logic       s1_is565_next, s1_is565_reg;
    logic [7:0] s1_fg_r_next, s1_fg_g_next, s1_fg_b_next;
    logic [7:0] s1_fg_r_reg, s1_fg_g_reg, s1_fg_b_reg;
    logic [7:0] s1_bg_r_next, s1_bg_g_next, s1_bg_b_next;
    logic [7:0] s1_bg_r_reg, s1_bg_g_reg, s1_bg_b_reg;
    logic [7:0] s1_alpha_reg;

    logic in_box, fmt_ok, on_edge, in_fill;

    always_comb
    begin
        in_box  = (in_data.col < box_width_reg) && (in_data.row < box_height_reg);
        fmt_ok  = (pixel_format_reg == FMT_RGB565) || (pixel_format_reg == FMT_ARGB8888);
        // box size is at least one here whenever in_box holds, so the minus one cannot wrap
        on_edge = (in_data.row == '0) || (in_data.row == box_height_reg - 1'b1) ||
                  (in_data.col == '0) || (in_data.col == box_width_reg - 1'b1);
        in_fill = in_data.col < fill_width_reg;
        s1_draw_next  = in_box && fmt_ok && (on_edge || in_fill);
        s1_is565_next = pixel_format_reg == FMT_RGB565;
        if (on_edge)
        begin
            s1_fg_r_next = EDGE_GREY;
            s1_fg_g_next = EDGE_GREY;
            s1_fg_b_next = EDGE_GREY;
        end
        else
        begin
            s1_fg_r_next = FILL_R;
            s1_fg_g_next = FILL_G;
            s1_fg_b_next = FILL_B;
        end
        if (s1_is565_next)
        begin
            s1_bg_r_next = {in_data.background_pixel[15:11], 3'b000};
            s1_bg_g_next = {in_data.background_pixel[10:5], 2'b00};
            s1_bg_b_next = {in_data.background_pixel[4:0], 3'b000};
        end
        else
        begin
            s1_bg_r_next = in_data.background_pixel[23:16];
            s1_bg_g_next = in_data.background_pixel[15:8];
            s1_bg_b_next = in_data.background_pixel[7:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_draw_reg  <= s1_draw_next;
            s1_is565_reg <= s1_is565_next;
            s1_fg_r_reg  <= s1_fg_r_next;
            s1_fg_g_reg  <= s1_fg_g_next;
            s1_fg_b_reg  <= s1_fg_b_next;
            s1_bg_r_reg  <= s1_bg_r_next;
            s1_bg_g_reg  <= s1_bg_g_next;
            s1_bg_b_reg  <= s1_bg_b_next;
            s1_alpha_reg <= opacity_reg;
        end
    end

    // stage 2: fg*a + bg*(255-a); an opacity of 255 gives fg back exactly
    logic [7:0]  inv_alpha;
    logic [15:0] s2_sum_r_next, s2_sum_g_next, s2_sum_b_next;
    logic [15:0] s2_sum_r_reg, s2_sum_g_reg, s2_sum_b_reg;
    logic        s2_draw_reg, s2_is565_reg;

    always_comb
    begin
        inv_alpha = ALPHA_OPAQUE - s1_alpha_reg;
        s2_sum_r_next = {8'b0, s1_fg_r_reg} * {8'b0, s1_alpha_reg}
                      + {8'b0, s1_bg_r_reg} * {8'b0, inv_alpha};
        s2_sum_g_next = {8'b0, s1_fg_g_reg} * {8'b0, s1_alpha_reg}
                      + {8'b0, s1_bg_g_reg} * {8'b0, inv_alpha};
        s2_sum_b_next = {8'b0, s1_fg_b_reg} * {8'b0, s1_alpha_reg}
                      + {8'b0, s1_bg_b_reg} * {8'b0, inv_alpha};
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready)
        begin
            s2_sum_r_reg <= s2_sum_r_next;
            s2_sum_g_reg <= s2_sum_g_next;
            s2_sum_b_reg <= s2_sum_b_next;
            s2_draw_reg  <= s1_draw_reg;
            s2_is565_reg <= s1_is565_reg;
        end
    end

    // stage 3: exact divide by 255 for sums up to 255*255
    logic [7:0] s3_r_reg, s3_g_reg, s3_b_reg;
    logic       s3_draw_reg, s3_is565_reg;

    always_ff @(posedge clk)
    begin
        if (s3_ready)
        begin
            s3_r_reg     <= div255(s2_sum_r_reg);
            s3_g_reg     <= div255(s2_sum_g_reg);
            s3_b_reg     <= div255(s2_sum_b_reg);
            s3_draw_reg  <= s2_draw_reg;
            s3_is565_reg <= s2_is565_reg;
        end
    end

    // stage 4: pack into the output register
    out_item_t s4_out_next, s4_out_reg;

    always_comb
    begin
        s4_out_next.write_pixel = s3_draw_reg;
        if (!s3_draw_reg)
            s4_out_next.new_pixel = '0;
        else if (s3_is565_reg)
            s4_out_next.new_pixel = {16'b0, s3_r_reg[7:3], s3_g_reg[7:2], s3_b_reg[7:3]};
        else
            s4_out_next.new_pixel = {ALPHA_OPAQUE, s3_r_reg, s3_g_reg, s3_b_reg};
    end

    always_ff @(posedge clk)
    begin
        if (s4_ready)
            s4_out_reg <= s4_out_next;
    end

    assign out_valid = s4_valid_reg;
    assign out_data  = s4_out_reg;

endmodule

// File: rtl/bba_checker.sv
module bba_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_ready,
    input  bba_pkg::in_item_t                    in_data,
    input  logic                                 out_valid,
    input  logic                                 out_ready,
    input  bba_pkg::out_item_t                   out_data,
    input  logic                                 cfg_write,
    input  logic [bba_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [bba_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
    import bba_pkg::*;

    // a stalled result item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled output item changed");

    // the input side only backs up when the output is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled while output is free");

    // a pixel that is not written carries a zero word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.write_pixel |-> out_data.new_pixel == '0)
        else $error("unwritten pixel has nonzero word");

    // written words are either rgb565 in the low half or opaque argb8888
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.write_pixel && out_data.new_pixel[31:24] != ALPHA_OPAQUE
        |-> out_data.new_pixel[31:16] == '0)
        else $error("written word is neither rgb565 nor opaque argb8888");

endmodule

bind bordered_bar_alpha_blend bba_checker u_bba_checker (.*);
